// File: src/pms_pkg.sv
// shared types and constants for the partitioned multi-stack block
// no dependencies; used by pms_ctrl, pms_dpath and partitioned_multi_stack
package pms_pkg;

	localparam int STACK_COUNT = 3;
	localparam int CAP_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int DATA_W      = 32;

	localparam logic [DATA_W-1:0] NEG_ONE = {DATA_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAP0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAP1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAP2 = 2'd2;

	localparam logic [CAP_W-1:0] CAP0_RESET = 8'd10;
	localparam logic [CAP_W-1:0] CAP1_RESET = 8'd15;
	localparam logic [CAP_W-1:0] CAP2_RESET = 8'd20;

	// stack selectors
	localparam logic [1:0] STACK_0 = 2'd0;
	localparam logic [1:0] STACK_1 = 2'd1;
	localparam logic [1:0] STACK_2 = 2'd2;

	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_POP  = 2'd1,
		KIND_PEEK = 2'd2,
		KIND_NOP  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_op;
		logic exec;
	} cmd_t;

endpackage

// File: src/pms_req_if.sv
// request channel: valid/ready handshake with one stack operation
// depends on nothing
interface pms_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [1:0]         stack_id;
	logic signed [31:0] value;

	modport source(output valid, kind, stack_id, value, input ready);
	modport sink(input valid, kind, stack_id, value, output ready);
endinterface

// File: src/pms_rsp_if.sv
// response channel: valid/ready handshake with one operation result
// depends on nothing
interface pms_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] read_value;
	logic [1:0]         status;
	logic               now_empty;
	logic               now_full;

	modport source(output valid, read_value, status, now_empty, now_full, input ready);
	modport sink(input valid, read_value, status, now_empty, now_full, output ready);
endinterface

// File: src/pms_ctrl.sv
// controller: sequences one operation at a time and owns the result valid flag
// depends on pms_pkg
module pms_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output pms_pkg::cmd_t  cmd
);

	pms_pkg::state_t state_q, state_nxt;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pms_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt   = state_q;
		req_ready   = 1'b0;
		cmd.load_op = 1'b0;
		cmd.exec    = 1'b0;
		case (state_q)
			pms_pkg::ST_IDLE: begin
				// the result slot is free or is being emptied this cycle
				req_ready   = !out_valid_q || rsp_ready;
				cmd.load_op = req_valid && req_ready;
				if (cmd.load_op) begin
					state_nxt = pms_pkg::ST_EXEC;
				end
			end
			pms_pkg::ST_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = pms_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = pms_pkg::ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

endmodule

// File: src/pms_dpath.sv
// datapath: capacity and fill registers, region arithmetic, stack memory, result registers
// depends on pms_pkg
module pms_dpath #(
	parameter int MEMORY_DEPTH = 128,
	parameter int WORD_WIDTH   = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pms_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [pms_pkg::CAP_W-1:0]            cfg_data,
	input  pms_pkg::cmd_t                        cmd,
	input  logic [1:0]                           req_kind,
	input  logic [1:0]                           req_stack_id,
	input  logic signed [pms_pkg::DATA_W-1:0]    req_value,
	output logic signed [pms_pkg::DATA_W-1:0]    read_value,
	output logic [1:0]                           status,
	output logic                                 now_empty,
	output logic                                 now_full
);

	localparam int AW     = $clog2(MEMORY_DEPTH);
	localparam int SLOT_W = (AW + 1 > pms_pkg::CAP_W + 2) ? AW + 1 : pms_pkg::CAP_W + 2;
	localparam int EXT_W  = (WORD_WIDTH > pms_pkg::DATA_W) ? WORD_WIDTH : pms_pkg::DATA_W;
	localparam int CW     = pms_pkg::CAP_W;

	logic [CW-1:0] cap_q  [pms_pkg::STACK_COUNT];
	logic [CW-1:0] fill_q [pms_pkg::STACK_COUNT];

	pms_pkg::kind_t               kind_q;
	logic [1:0]                   sid_q;
	logic signed [pms_pkg::DATA_W-1:0] value_q;

	logic [WORD_WIDTH-1:0]        mem [MEMORY_DEPTH];
	logic signed [WORD_WIDTH-1:0] rdata_q;

	pms_pkg::status_t status_q;
	logic             empty_q;
	logic             full_q;
	logic             hit_q;

	// execute-cycle signals
	logic              sid_ok;
	logic [1:0]        sel;
	logic [SLOT_W-1:0] base;
	logic [CW-1:0]     fill_cur;
	logic [CW-1:0]     cap_cur;
	logic [CW-1:0]     fill_nxt;
	logic [SLOT_W-1:0] slot;
	logic [SLOT_W-1:0] slot_nxt;
	logic [SLOT_W-1:0] addr;
	logic              full_cur;
	logic              mem_we;
	logic              mem_re;
	logic              fill_we;
	pms_pkg::status_t  status_nxt;
	logic              empty_nxt;
	logic              full_nxt;
	logic [EXT_W-1:0]  wdata_ext;
	logic [EXT_W-1:0]  rdata_ext;

	always_comb begin
		sid_ok = 1'b1;
		sel    = req_stack_id;
		case (sid_q)
			pms_pkg::STACK_0: sel = pms_pkg::STACK_0;
			pms_pkg::STACK_1: sel = pms_pkg::STACK_1;
			pms_pkg::STACK_2: sel = pms_pkg::STACK_2;
			default: begin
				sid_ok = 1'b0;
				sel    = pms_pkg::STACK_0;
			end
		endcase

		// regions are laid out back to back
		case (sel)
			pms_pkg::STACK_1: base = SLOT_W'(cap_q[0]);
			pms_pkg::STACK_2: base = SLOT_W'(cap_q[0]) + SLOT_W'(cap_q[1]);
			default:          base = '0;
		endcase

		fill_cur = fill_q[sel];
		cap_cur  = cap_q[sel];
		slot     = base + SLOT_W'(fill_cur);
		full_cur = (fill_cur >= cap_cur) || (slot >= SLOT_W'(MEMORY_DEPTH));

		fill_nxt   = fill_cur;
		status_nxt = pms_pkg::STATUS_DONE;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		addr       = slot;
		case (kind_q)
			pms_pkg::KIND_PUSH: begin
				if (full_cur) begin
					status_nxt = pms_pkg::STATUS_FULL;
				end else begin
					mem_we   = 1'b1;
					fill_nxt = fill_cur + CW'(1);
				end
			end
			pms_pkg::KIND_POP, pms_pkg::KIND_PEEK: begin
				addr = slot - SLOT_W'(1);
				if (fill_cur == '0) begin
					status_nxt = pms_pkg::STATUS_EMPTY;
				end else begin
					mem_re = 1'b1;
					if (kind_q == pms_pkg::KIND_POP) begin
						fill_nxt = fill_cur - CW'(1);
					end
				end
			end
			default: begin
			end
		endcase

		slot_nxt  = base + SLOT_W'(fill_nxt);
		empty_nxt = (fill_nxt == '0);
		full_nxt  = (fill_nxt >= cap_cur) || (slot_nxt >= SLOT_W'(MEMORY_DEPTH));
		fill_we   = cmd.exec && sid_ok;

		// nonexistent stack: no change, reported empty and full
		if (!sid_ok) begin
			mem_we     = 1'b0;
			mem_re     = 1'b0;
			status_nxt = pms_pkg::STATUS_EMPTY;
			empty_nxt  = 1'b1;
			full_nxt   = 1'b1;
		end
	end

	assign wdata_ext = EXT_W'(value_q);
	assign rdata_ext = EXT_W'(rdata_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q[0] <= pms_pkg::CAP0_RESET;
			cap_q[1] <= pms_pkg::CAP1_RESET;
			cap_q[2] <= pms_pkg::CAP2_RESET;
			for (int i = 0; i < pms_pkg::STACK_COUNT; i++) begin
				fill_q[i] <= '0;
			end
		end else if (cfg_we) begin
			// moving any region empties every stack
			case (cfg_idx)
				pms_pkg::CFG_CAP0, pms_pkg::CFG_CAP1, pms_pkg::CFG_CAP2: begin
					cap_q[cfg_idx] <= cfg_data;
					for (int i = 0; i < pms_pkg::STACK_COUNT; i++) begin
						fill_q[i] <= '0;
					end
				end
				default: begin
				end
			endcase
		end else if (fill_we) begin
			fill_q[sel] <= fill_nxt;
		end
	end

	// operation and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			kind_q  <= pms_pkg::kind_t'(req_kind);
			sid_q   <= req_stack_id;
			value_q <= req_value;
		end
		if (cmd.exec) begin
			status_q <= status_nxt;
			empty_q  <= empty_nxt;
			full_q   <= full_nxt;
			hit_q    <= mem_re;
		end
	end

	// single-port stack memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.exec && mem_we) begin
			mem[addr[AW-1:0]] <= wdata_ext[WORD_WIDTH-1:0];
		end
		if (cmd.exec && mem_re) begin
			rdata_q <= mem[addr[AW-1:0]];
		end
	end

	assign read_value = hit_q ? rdata_ext[pms_pkg::DATA_W-1:0] : pms_pkg::NEG_ONE;
	assign status     = status_q;
	assign now_empty  = empty_q;
	assign now_full   = full_q;

endmodule

// File: src/partitioned_multi_stack.sv
// three stacks in one word memory; a request is registered in the operation registers,
// then executed in the execute state, which sets the result valid flag; no new request is
// accepted during that memory access (single-port stack memory with registered read); a new
// request is taken as the previous result is taken; reset restores capacities 10, 15, 20 and
// empties all stacks, memory contents are not cleared
module partitioned_multi_stack #(
	parameter int MEMORY_DEPTH = 128,
	parameter int WORD_WIDTH   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pms_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [pms_pkg::CAP_W-1:0]     cfg_data,
	pms_req_if.sink                       req,
	pms_rsp_if.source                     rsp
);

	pms_pkg::cmd_t cmd;

	pms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	pms_dpath #(
		.MEMORY_DEPTH (MEMORY_DEPTH),
		.WORD_WIDTH   (WORD_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.req_kind     (req.kind),
		.req_stack_id (req.stack_id),
		.req_value    (req.value),
		.read_value   (rsp.read_value),
		.status       (rsp.status),
		.now_empty    (rsp.now_empty),
		.now_full     (rsp.now_full)
	);

endmodule
